// ===== hw/rtl/boc_pkg.sv =====
package boc_pkg;

    localparam int PORTS       = 64;
    localparam int PRIORITIES  = 8;
    localparam int GROUPS      = 8;
    localparam int COUNT_W     = 32;

    // queue slots per port are fixed at eight, as in the queue numbering
    localparam int SLOTS_PER_PORT = 8;
    localparam int QUEUE_SLOTS    = PORTS * SLOTS_PER_PORT;

    localparam int PORT_AW  = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int QUEUE_AW = $clog2(QUEUE_SLOTS);

    // fixed field widths
    localparam int MAP_W    = 24;
    localparam int GIDX_W   = 3;
    localparam int PIDX_W   = 6;
    localparam int PRIO_W   = 3;
    localparam int QIDX_W   = 9;
    localparam int PKT_W    = 14;
    localparam int BYTES_W  = 32;

    localparam int IN_W  = 24;
    localparam int OUT_W = 120;

    // result word layout, lowest bit first
    localparam int O_GIDX = 0;
    localparam int O_GB   = O_GIDX + GIDX_W;
    localparam int O_PIDX = O_GB + BYTES_W;
    localparam int O_PB   = O_PIDX + PIDX_W;
    localparam int O_QIDX = O_PB + BYTES_W;
    localparam int O_QB   = O_QIDX + QIDX_W;
    localparam int O_UF   = O_QB + BYTES_W;
    localparam int O_USED = O_UF + 1;

    typedef enum logic
    {
        MODE_ADD = 1'b0,
        MODE_SUB = 1'b1
    } mode_t;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed
    {
        count_t           cur;
        logic [PKT_W-1:0] bytes;
        mode_t            mode;
    } upd_req_t;

    typedef struct packed
    {
        count_t value;
        logic   clamp;
    } upd_res_t;

endpackage

// ===== hw/rtl/boc_sat_unit.sv =====
module boc_sat_unit
    import boc_pkg::*;
(
    input  upd_req_t req,
    output upd_res_t res
);

    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] bytes_ext;

    assign bytes_ext = COUNT_W'(req.bytes);
    assign sum       = {1'b0, req.cur} + {1'b0, bytes_ext};

    always_comb
    begin
        res.clamp = 1'b0;
        case (req.mode)
            MODE_ADD:
            begin
                // carry out means the sum passed the top: hold at all ones
                res.value = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
            end
            MODE_SUB:
            begin
                if (bytes_ext > req.cur)
                begin
                    res.value = '0;
                    res.clamp = 1'b1;
                end
                else
                begin
                    res.value = req.cur - bytes_ext;
                end
            end
            default:
            begin
                res.value = req.cur;
            end
        endcase
    end

endmodule

// ===== hw/rtl/buffer_occupancy_tracker.sv =====
// Buffer occupancy tracker: takes one packet event per cycle (add on accept, subtract on
// transmit) when the output is not stalled, and returns one result per event with the new
// byte counts of the memory group, the port and the port-priority queue. Queue and port
// counts live in single-port-read synchronous memories; each event is a read-modify-write,
// and a one-entry bypass of the last write lets events follow each other every cycle, so the
// sustained rate is one event per clock while m_tready stays high. The request is registered
// in stage 1 and the result register loads from it when stage 1 fires. After reset a clearing
// pass zeroes both memories; s_tready stays low for that time, while cfg writes are taken as
// usual. Counts saturate on add and clamp at zero on subtract, with underflow raised.
module buffer_occupancy_tracker
    import boc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_we,
    input  logic [MAP_W-1:0] cfg_wdata,   // priority_group_map

    input  logic             s_tvalid,
    output logic             s_tready,
    // mode[0], egress_port[6:1], priority_level[9:7], packet_bytes[23:10]
    input  logic [IN_W-1:0]  s_tdata,

    output logic             m_tvalid,
    input  logic             m_tready,
    // group_index[2:0], group_bytes[34:3], port_index[40:35], port_bytes[72:41],
    // queue_index[81:73], queue_bytes[113:82], underflow[114], zero[119:115]
    output logic [OUT_W-1:0] m_tdata
);

    // ---------------- configuration ----------------
    logic [MAP_W-1:0] map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            map_reg <= '0;
        else if (cfg_we)
            map_reg <= cfg_wdata;
    end

    // ---------------- request decode ----------------
    mode_t             in_mode;
    logic [PIDX_W-1:0] in_port;
    logic [PRIO_W-1:0] in_prio;
    logic [PKT_W-1:0]  in_bytes;
    logic [GIDX_W-1:0] in_group;
    logic [QIDX_W-1:0] in_queue;
    logic              in_ok;
    logic              s_accept;

    assign in_mode  = mode_t'(s_tdata[0]);
    assign in_port  = s_tdata[6:1];
    assign in_prio  = s_tdata[9:7];
    assign in_bytes = s_tdata[23:10];
    assign in_group = map_reg[int'(in_prio) * GIDX_W +: GIDX_W];
    assign in_queue = QIDX_W'({in_port, in_prio});
    assign in_ok    = (int'(in_port) < PORTS) && (int'(in_prio) < PRIORITIES) &&
                      (int'(in_group) < GROUPS);
    assign s_accept = s_tvalid && s_tready;

    // ---------------- clearing pass ----------------
    logic                clearing_reg, clearing_next;
    logic [QUEUE_AW-1:0] clr_idx_reg, clr_idx_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == QUEUE_AW'(QUEUE_SLOTS - 1))
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // ---------------- stage 1 (memory data returns) ----------------
    logic              s1_valid_reg, s1_valid_next;
    mode_t             s1_mode_reg;
    logic [PIDX_W-1:0] s1_port_reg;
    logic [GIDX_W-1:0] s1_group_reg;
    logic [QIDX_W-1:0] s1_queue_reg;
    logic [PKT_W-1:0]  s1_bytes_reg;
    logic              s1_ok_reg;
    logic              s1_fire;
    logic              m_valid_reg, m_valid_next;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_fire);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_mode_reg  <= in_mode;
            s1_port_reg  <= in_port;
            s1_group_reg <= in_group;
            s1_queue_reg <= in_queue;
            s1_bytes_reg <= in_bytes;
            s1_ok_reg    <= in_ok;
        end
    end

    // ---------------- counter memories ----------------
    count_t              q_mem [QUEUE_SLOTS];
    count_t              p_mem [PORTS];
    count_t              q_rdata_reg;
    count_t              p_rdata_reg;
    logic                q_we, p_we;
    logic [QUEUE_AW-1:0] q_waddr;
    logic [PORT_AW-1:0]  p_waddr;
    count_t              q_wdata, p_wdata;
    logic                upd_we;
    count_t              q_new, p_new;

    assign upd_we  = s1_fire && s1_ok_reg;
    assign q_we    = clearing_reg || upd_we;
    assign p_we    = clearing_reg || upd_we;
    assign q_waddr = clearing_reg ? clr_idx_reg : QUEUE_AW'(s1_queue_reg);
    assign p_waddr = clearing_reg ? clr_idx_reg[PORT_AW-1:0] : PORT_AW'(s1_port_reg);
    assign q_wdata = clearing_reg ? '0 : q_new;
    assign p_wdata = clearing_reg ? '0 : p_new;

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
        if (s_accept)
            q_rdata_reg <= q_mem[QUEUE_AW'(in_queue)];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            p_mem[p_waddr] <= p_wdata;
        if (s_accept)
            p_rdata_reg <= p_mem[PORT_AW'(in_port)];
    end

    // bypass of the last update write; a read on the same edge sees the old word
    logic                q_fwd_valid_reg, p_fwd_valid_reg;
    logic [QIDX_W-1:0]   q_fwd_addr_reg;
    logic [PIDX_W-1:0]   p_fwd_addr_reg;
    count_t              q_fwd_data_reg, p_fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_fwd_valid_reg <= 1'b0;
            p_fwd_valid_reg <= 1'b0;
        end
        else if (upd_we)
        begin
            q_fwd_valid_reg <= 1'b1;
            p_fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            q_fwd_addr_reg <= s1_queue_reg;
            q_fwd_data_reg <= q_new;
            p_fwd_addr_reg <= s1_port_reg;
            p_fwd_data_reg <= p_new;
        end
    end

    // group counters are few enough to sit in flops
    count_t grp_cnt_reg [GROUPS];
    count_t g_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
                grp_cnt_reg[i] <= '0;
        end
        else if (upd_we)
        begin
            grp_cnt_reg[s1_group_reg] <= g_new;
        end
    end

    // ---------------- update ----------------
    upd_req_t g_req, p_req, q_req;
    upd_res_t g_res, p_res, q_res;

    always_comb
    begin
        g_req.cur   = grp_cnt_reg[s1_group_reg];
        g_req.bytes = s1_bytes_reg;
        g_req.mode  = s1_mode_reg;

        p_req.cur   = (p_fwd_valid_reg && p_fwd_addr_reg == s1_port_reg) ?
                      p_fwd_data_reg : p_rdata_reg;
        p_req.bytes = s1_bytes_reg;
        p_req.mode  = s1_mode_reg;

        q_req.cur   = (q_fwd_valid_reg && q_fwd_addr_reg == s1_queue_reg) ?
                      q_fwd_data_reg : q_rdata_reg;
        q_req.bytes = s1_bytes_reg;
        q_req.mode  = s1_mode_reg;
    end

    boc_sat_unit u_grp_sat
    (
        .req (g_req),
        .res (g_res)
    );

    boc_sat_unit u_port_sat
    (
        .req (p_req),
        .res (p_res)
    );

    boc_sat_unit u_queue_sat
    (
        .req (q_req),
        .res (q_res)
    );

    assign g_new = g_res.value;
    assign p_new = p_res.value;
    assign q_new = q_res.value;

    // ---------------- result register ----------------
    logic [OUT_W-1:0] m_data_reg, m_data_next;
    logic             ok;

    assign ok = s1_ok_reg;

    always_comb
    begin
        m_data_next = '0;
        m_data_next[O_GIDX +: GIDX_W]  = s1_group_reg;
        m_data_next[O_GB   +: BYTES_W] = ok ? BYTES_W'(g_new) : '0;
        m_data_next[O_PIDX +: PIDX_W]  = s1_port_reg;
        m_data_next[O_PB   +: BYTES_W] = ok ? BYTES_W'(p_new) : '0;
        m_data_next[O_QIDX +: QIDX_W]  = s1_queue_reg;
        m_data_next[O_QB   +: BYTES_W] = ok ? BYTES_W'(q_new) : '0;
        m_data_next[O_UF]              = ok && (g_res.clamp || p_res.clamp || q_res.clamp);
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s1_fire)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_queue_reg))
        else $error("stage 1 request lost while output stalled");

    a_add_no_uf: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_mode_reg == MODE_ADD |=> !m_data_reg[O_UF])
        else $error("underflow raised on an add");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_ok_reg |=> m_data_reg[O_QB +: BYTES_W] == '0 && !m_data_reg[O_UF])
        else $error("out of range event reported a count");

    a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> $past(clr_idx_reg) == QUEUE_AW'(QUEUE_SLOTS - 1))
        else $error("clearing pass ended early");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !m_valid_reg)
        else $error("request in flight during clearing pass");

endmodule
